// ===== sv/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, also evaluated during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sep_pkg.sv =====
// Shared types and constants for the SSE stream parser.
// No dependencies.
package sep_pkg;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_NAME_CLR = 2'd1,
		KIND_NAME     = 2'd2,
		KIND_END      = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic        done;
		logic        last;
	} res_t;

	// Results produced by one input byte, in output order.
	typedef struct packed {
		res_t        r0;
		res_t        r1;
		logic [1:0]  n;
	} res_pair_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== sv/sep_parser.sv =====
// Parser state and per-byte result logic for the SSE stream parser.
// Depends on sep_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sep_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          char_s1,
	output sep_pkg::res_pair_t  res
);
	import sep_pkg::*;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_FIELD = 2'd1,
		PH_VALUE = 2'd2,
		PH_SKIP  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_DATA  = 2'd1,
		TGT_EVENT = 2'd2
	} tgt_t;

	localparam logic [2:0] MATCH_FAIL = 3'd7;
	localparam logic [2:0] DONE_FULL  = 3'd6;
	localparam logic [2:0] LEN_DATA   = 3'd4;
	localparam logic [2:0] LEN_EVENT  = 3'd5;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  fmatch;
		tgt_t        target;
		logic        held_cr;
		logic        vfirst;
		logic        dnon;
		logic        nnon;
		logic [2:0]  dmatch;
		logic        sdone;
	} st_t;

	typedef struct packed {
		st_t   st;
		logic  v;
		res_t  r;
		logic  hit;
	} proc_t;

	function automatic logic [7:0] data_ch(logic [2:0] i);
		logic [7:0] ch;
		unique case (i)
			3'd0: ch = "d";
			3'd1: ch = "a";
			3'd2: ch = "t";
			3'd3: ch = "a";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] event_ch(logic [2:0] i);
		logic [7:0] ch;
		unique case (i)
			3'd0: ch = "e";
			3'd1: ch = "v";
			3'd2: ch = "e";
			3'd3: ch = "n";
			3'd4: ch = "t";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] done_ch(logic [2:0] i);
		logic [7:0] ch;
		unique case (i)
			3'd0: ch = "[";
			3'd1: ch = "D";
			3'd2: ch = "O";
			3'd3: ch = "N";
			3'd4: ch = "E";
			3'd5: ch = "]";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
			(c == 8'h0C) || (c == 8'h0D);
	endfunction

	// [DONE] tracker: leading/trailing whitespace allowed, letters any case.
	function automatic logic [2:0] done_next(logic [2:0] dm, logic [7:0] c);
		logic [7:0] u;
		logic [2:0] n;
		u = ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
		n = dm;
		if (is_ws(c)) begin
			if ((dm >= 3'd1) && (dm <= 3'd5))
				n = MATCH_FAIL;
		end else if (dm < DONE_FULL) begin
			n = (u == done_ch(dm)) ? (dm + 3'd1) : MATCH_FAIL;
		end else begin
			n = MATCH_FAIL;
		end
		return n;
	endfunction

	function automatic proc_t data_byte(st_t s, logic [7:0] c);
		proc_t p;
		p = '0;
		p.st = s;
		p.v = 1'b1;
		p.r.kind = KIND_DATA;
		p.r.ch = c;
		p.st.dnon = 1'b1;
		p.st.dmatch = done_next(s.dmatch, c);
		return p;
	endfunction

	// Field name complete: data adds a separator, event clears the name.
	function automatic proc_t field_end(st_t s);
		proc_t p;
		p = '0;
		p.st = s;
		if ((s.target == TGT_DATA) && (s.fmatch == LEN_DATA)) begin
			if (s.dnon)
				p = data_byte(s, CH_LF);
			p.hit = 1'b1;
		end else if ((s.target == TGT_EVENT) && (s.fmatch == LEN_EVENT)) begin
			p.v = 1'b1;
			p.r.kind = KIND_NAME_CLR;
			p.st.nnon = 1'b0;
			p.hit = 1'b1;
		end
		return p;
	endfunction

	function automatic st_t field_char(st_t s, logic [7:0] c);
		st_t n;
		logic [2:0] len;
		logic [7:0] w;
		n = s;
		len = (s.target == TGT_DATA) ? LEN_DATA : LEN_EVENT;
		w = (s.target == TGT_DATA) ? data_ch(s.fmatch) : event_ch(s.fmatch);
		if (s.fmatch == 3'd0) begin
			if (c == "d") begin
				n.target = TGT_DATA;
				n.fmatch = 3'd1;
			end else if (c == "e") begin
				n.target = TGT_EVENT;
				n.fmatch = 3'd1;
			end else begin
				n.fmatch = MATCH_FAIL;
			end
		end else if (s.fmatch != MATCH_FAIL) begin
			if ((s.fmatch < len) && (c == w))
				n.fmatch = s.fmatch + 3'd1;
			else
				n.fmatch = MATCH_FAIL;
		end
		return n;
	endfunction

	// One byte after CR handling; gives at most one result.
	function automatic proc_t process(st_t s, logic [7:0] c);
		proc_t p;
		st_t t;
		p = '0;
		p.st = s;
		if (c == CH_LF) begin
			if (s.phase == PH_START) begin
				if (s.dnon || s.nnon) begin
					p.v = 1'b1;
					p.r.kind = KIND_END;
					p.r.done = (s.dmatch == DONE_FULL);
					p.st.sdone = (s.dmatch == DONE_FULL);
				end
				p.st.dnon = 1'b0;
				p.st.nnon = 1'b0;
				p.st.dmatch = 3'd0;
			end else if (s.phase == PH_FIELD) begin
				p = field_end(s);
			end
			p.st.phase = PH_START;
			p.st.fmatch = 3'd0;
			p.st.target = TGT_NONE;
			p.st.vfirst = 1'b0;
		end else begin
			unique case (s.phase)
				PH_START: begin
					if (c == CH_COLON) begin
						p.st.phase = PH_SKIP;
					end else begin
						t = s;
						t.phase = PH_FIELD;
						t.fmatch = 3'd0;
						t.target = TGT_NONE;
						p.st = field_char(t, c);
					end
				end
				PH_FIELD: begin
					if (c == CH_COLON) begin
						p = field_end(s);
						if (p.hit) begin
							p.st.phase = PH_VALUE;
							p.st.vfirst = 1'b1;
						end else begin
							p.st.phase = PH_SKIP;
						end
					end else begin
						p.st = field_char(s, c);
					end
				end
				PH_VALUE: begin
					if (s.vfirst && (c == CH_SPACE)) begin
						p.st.vfirst = 1'b0;
					end else begin
						t = s;
						t.vfirst = 1'b0;
						if (s.target == TGT_DATA) begin
							p = data_byte(t, c);
						end else begin
							p.st = t;
							p.v = 1'b1;
							p.r.kind = KIND_NAME;
							p.r.ch = c;
							p.st.nnon = 1'b1;
						end
					end
				end
				PH_SKIP: ;
			endcase
		end
		p.hit = 1'b0;
		return p;
	endfunction

	st_t   st_q;
	st_t   st_mid;
	st_t   st_nxt;
	proc_t p_cr;
	proc_t p_ch;
	logic  v_cr;
	logic  v_ch;

	always_comb begin
		p_cr = '0;
		p_ch = '0;
		v_cr = 1'b0;
		v_ch = 1'b0;
		st_mid = st_q;
		st_nxt = st_q;
		if (!st_q.sdone) begin
			// A held CR not followed by LF is an ordinary byte, handled first.
			st_mid.held_cr = 1'b0;
			if (st_q.held_cr && (char_s1 != CH_LF)) begin
				p_cr = process(st_mid, CH_CR);
				v_cr = p_cr.v;
				st_mid = p_cr.st;
			end
			st_nxt = st_mid;
			if (char_s1 == CH_CR) begin
				st_nxt.held_cr = 1'b1;
			end else begin
				p_ch = process(st_mid, char_s1);
				v_ch = p_ch.v;
				st_nxt = p_ch.st;
			end
		end
	end

	always_comb begin
		res = '0;
		res.n = {1'b0, v_cr} + {1'b0, v_ch};
		if (v_cr) begin
			res.r0 = p_cr.r;
			res.r0.last = !v_ch;
			res.r1 = p_ch.r;
			res.r1.last = 1'b1;
		end else begin
			res.r0 = p_ch.r;
			res.r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_START, fmatch: 3'd0, target: TGT_NONE, held_cr: 1'b0,
				vfirst: 1'b0, dnon: 1'b0, nnon: 1'b0, dmatch: 3'd0, sdone: 1'b0};
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

	`ASSERT_CLK(a_done_sticky, st_q.sdone |=> st_q.sdone, "stream done flag dropped")
	`ASSERT_CLK(a_end_is_last, (res.n == 2'd2) |-> (res.r0.kind != KIND_END), "event end not last")
	`ASSERT_CLK(a_cr_held, (step && !st_q.sdone && (char_s1 == CH_CR)) |=> st_q.held_cr, "CR not held")

endmodule

// ===== sv/sep_res_fifo.sv =====
// Small result queue: up to two pushes and one pop per cycle.
// Depends on sep_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sep_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sep_pkg::res_pair_t  wr,
	input  logic                pop,
	output sep_pkg::res_t       head,
	output logic                not_empty,
	output logic                room2
);
	import sep_pkg::*;

	res_t                mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_CW-1:0]  count_q;
	logic [1:0]          push_n;

	assign push_n    = push ? wr.n : 2'd0;
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wr_ptr_q] <= wr.r0;
		if (push_n == 2'd2)
			mem[wr_ptr_q + FIFO_AW'(1)] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	`ASSERT_CLK(a_cnt_max, count_q <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
	`ASSERT_CLK(a_no_underflow, pop |-> (count_q != '0), "pop from empty result queue")

endmodule

// ===== sv/sse_event_stream_parser.sv =====
// Top level of the server-sent-events stream parser.
// Depends on sep_pkg, sep_parser and sep_res_fifo.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  input   | in_valid / in_ready  | char_in[7:0]
//  output  | out_valid / out_ready| kind[1:0] char_out[7:0] done_flag last
//
// One input byte per cycle is sustained while the queue has room: a byte
// sits in the input register while the parser logic forms its results,
// then up to two results go into a four-entry queue. A byte leaves the
// input register only when the queue has room for two results, so the
// queue occupancy sets the stall. Results pass the queue to the output.
// Reset (arst_n low) clears parser state, the input register and the queue.
// A byte that yields two results (lone CR then another byte) needs two
// output pops to drain, so sustained input rate follows output rate.
module sse_event_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  char_out,
	output logic        done_flag,
	output logic        last
);
	import sep_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       room2;
	logic       advance;
	res_pair_t  res;
	res_t       head;

	// Byte in stage 1 is processed and retired once two queue slots are free.
	assign advance  = valid_s1 && room2;
	assign in_ready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			char_s1 <= char_in;
	end

	sep_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.char_s1 (char_s1),
		.res     (res)
	);

	sep_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.wr        (res),
		.pop       (out_valid && out_ready),
		.head      (head),
		.not_empty (out_valid),
		.room2     (room2)
	);

	assign kind      = head.kind;
	assign char_out  = head.ch;
	assign done_flag = head.done;
	assign last      = head.last;

endmodule

// ===== dv/tb_sse_event_stream_parser.sv =====
// Testbench for sse_event_stream_parser: byte stream in, parse results out.
// Depends on sep_pkg and the parser RTL; checks every result against an
// in-bench line parser under random idling and a long output hold-off.
`timescale 1ns / 1ps

module tb_sse_event_stream_parser;
	import sep_pkg::*;

	typedef enum logic [1:0] {PH_START, PH_FIELD, PH_VALUE, PH_SKIP} line_phase_t;
	typedef enum logic [1:0] {TGT_NONE, TGT_DATA, TGT_EVENT} field_tgt_t;

	localparam logic [2:0]  MATCH_FAIL = 3'd7;
	localparam logic [2:0]  DONE_FULL  = 3'd6;
	localparam logic [31:0] WORD_DATA  = "data";
	localparam logic [39:0] WORD_EVENT = "event";
	localparam logic [47:0] WORD_DONE  = "[DONE]";
	localparam logic [7:0]  CH_TAB     = 8'h09;
	localparam logic [7:0]  CH_VT      = 8'h0B;
	localparam logic [7:0]  CH_FF      = 8'h0C;

	localparam int STALL_LIMIT  = 2000;	// cycles with no transaction on either side
	localparam int HOLD_CYCLES  = 300;	// output hold-off for the backpressure test
	localparam int DRAIN_CYCLES = 8;	// settle time after the last expected result

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_in = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic       done_flag;
	logic       last;

	sse_event_stream_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.char_out  (char_out),
		.done_flag (done_flag),
		.last      (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Line parser mirror. Updated once per accepted input transaction.
	// ------------------------------------------------------------------
	line_phase_t ph = PH_START;
	field_tgt_t  tgt = TGT_NONE;
	logic [2:0]  fmatch = 3'd0;
	logic [2:0]  done_state = 3'd0;	// progress of "[DONE]" over pending data
	logic        cr_held = 1'b0;
	logic        val_first = 1'b0;
	logic        data_pend = 1'b0;
	logic        name_pend = 1'b0;
	logic        stream_closed = 1'b0;

	res_t byte_results[$];		// results of the byte being parsed
	res_t out_expect_q[$];		// results still owed by the DUT, oldest first

	int err_cnt = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;

	function automatic bit is_ws(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic logic [7:0] done_char(input int i);
		return WORD_DONE[47 - 8 * i -: 8];
	endfunction

	function void emit_res(input kind_t k, input logic [7:0] ch, input logic d);
		res_t r;
		r.kind = k;
		r.ch   = ch;
		r.done = d;
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	function void track_done(input logic [7:0] c);
		logic [7:0] u;
		if (is_ws(c)) begin
			if (done_state >= 3'd1 && done_state <= 3'd5)
				done_state = MATCH_FAIL;
		end else if (done_state < DONE_FULL) begin
			u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
			done_state = (u == done_char(done_state)) ? done_state + 3'd1 : MATCH_FAIL;
		end else begin
			done_state = MATCH_FAIL;
		end
	endfunction

	function void push_data_byte(input logic [7:0] c);
		emit_res(KIND_DATA, c, 1'b0);
		data_pend = 1'b1;
		track_done(c);
	endfunction

	// Acts on a finished field name; true for data and event.
	function bit close_field_name();
		if (tgt == TGT_DATA && fmatch == 3'd4) begin
			if (data_pend)
				push_data_byte(CH_LF);
			return 1'b1;
		end
		if (tgt == TGT_EVENT && fmatch == 3'd5) begin
			emit_res(KIND_NAME_CLR, 8'h00, 1'b0);
			name_pend = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function void match_field_char(input logic [7:0] c);
		int         wlen;
		logic [7:0] w;
		if (fmatch == 3'd0) begin
			if (c == "d") begin
				tgt = TGT_DATA;
				fmatch = 3'd1;
			end else if (c == "e") begin
				tgt = TGT_EVENT;
				fmatch = 3'd1;
			end else begin
				fmatch = MATCH_FAIL;
			end
		end else if (fmatch != MATCH_FAIL) begin
			wlen = (tgt == TGT_DATA) ? 4 : 5;
			w = (tgt == TGT_DATA) ? WORD_DATA[31 - 8 * fmatch -: 8] :
				WORD_EVENT[39 - 8 * fmatch -: 8];
			if (fmatch < wlen && c == w)
				fmatch = fmatch + 3'd1;
			else
				fmatch = MATCH_FAIL;
		end
	endfunction

	function void line_byte(input logic [7:0] c);
		logic fin;
		if (c == CH_LF) begin
			if (ph == PH_START) begin
				if (data_pend || name_pend) begin
					fin = (done_state == DONE_FULL);
					emit_res(KIND_END, 8'h00, fin);
					if (fin)
						stream_closed = 1'b1;
				end
				data_pend = 1'b0;
				name_pend = 1'b0;
				done_state = 3'd0;
			end else if (ph == PH_FIELD) begin
				void'(close_field_name());
			end
			ph = PH_START;
			fmatch = 3'd0;
			tgt = TGT_NONE;
			val_first = 1'b0;
			return;
		end
		case (ph)
			PH_START: begin
				if (c == CH_COLON) begin
					ph = PH_SKIP;
				end else begin
					ph = PH_FIELD;
					fmatch = 3'd0;
					tgt = TGT_NONE;
					match_field_char(c);
				end
			end
			PH_FIELD: begin
				if (c == CH_COLON) begin
					if (close_field_name()) begin
						ph = PH_VALUE;
						val_first = 1'b1;
					end else begin
						ph = PH_SKIP;
					end
				end else begin
					match_field_char(c);
				end
			end
			PH_VALUE: begin
				if (val_first && c == CH_SPACE) begin
					val_first = 1'b0;
				end else begin
					val_first = 1'b0;
					if (tgt == TGT_DATA) begin
						push_data_byte(c);
					end else begin
						emit_res(KIND_NAME, c, 1'b0);
						name_pend = 1'b1;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Expected results of one accepted byte, appended to out_expect_q.
	function void parse_byte(input logic [7:0] c);
		byte_results.delete();
		if (stream_closed)
			return;
		// a held CR only counts as a byte if no LF follows it
		if (cr_held) begin
			cr_held = 1'b0;
			if (c != CH_LF)
				line_byte(CH_CR);
		end
		if (c == CH_CR)
			cr_held = 1'b1;
		else
			line_byte(c);
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i])
			out_expect_q.push_back(byte_results[i]);
	endfunction

	// True if this byte would close an event whose data reads [DONE].
	function bit ends_stream(input logic [7:0] c);
		return !stream_closed && c == CH_LF && ph == PH_START &&
			(data_pend || name_pend) && done_state == DONE_FULL;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		char_in <= c;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		parse_byte(c);
	endtask

	// Keeps the stream alive: a blank line that would end it is turned
	// into a comment line instead.
	task automatic send_live(input logic [7:0] c);
		send_byte(ends_stream(c) ? CH_COLON : c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_live(s[i]);
	endtask

	// ------------------------------------------------------------------
	// Output side: checker and ready generator share one process
	// ------------------------------------------------------------------
	int hold_left = 0;

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (out_expect_q.size() == 0) begin
				$error("unexpected result: kind %0d char_out %02h done_flag %0b last %0b",
					kind, char_out, done_flag, last);
				err_cnt++;
			end else begin
				e = out_expect_q.pop_front();
				if (kind !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, kind);
					err_cnt++;
				end
				if (char_out !== e.ch) begin
					$error("char_out: expected %02h, got %02h", e.ch, char_out);
					err_cnt++;
				end
				if (done_flag !== e.done) begin
					$error("done_flag: expected %0b, got %0b", e.done, done_flag);
					err_cnt++;
				end
				if (last !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, last);
					err_cnt++;
				end
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: any transaction on either side restarts the count.
	int stall_cnt = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Random stream generation
	// ------------------------------------------------------------------
	function automatic logic [7:0] value_char();
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			c = 8'($urandom_range(8'h21, 8'h7E));
		end else if (r < 65) begin
			c = CH_SPACE;
		end else if (r < 70) begin
			c = CH_CR;
		end else if (r < 77) begin
			c = 8'($urandom_range(CH_TAB, CH_FF));
		end else if (r < 90) begin
			c = done_char($urandom_range(0, 5));
			if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
				c = c + 8'd32;
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	task automatic send_ws(input int n);
		for (int i = 0; i < n; i++)
			send_live($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	// Value part of a line: often a near or exact [DONE], else random bytes.
	task automatic send_value();
		int         n;
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0) begin
			send_ws($urandom_range(0, 2));
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 6;
			for (int i = 0; i < n; i++) begin
				c = done_char(i);
				if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
					c = c + 8'd32;
				send_live(c);
			end
			send_ws($urandom_range(0, 2));
			if ($urandom_range(0, 9) == 0)
				send_live(value_char());
		end else begin
			n = $urandom_range(0, 10);
			for (int i = 0; i < n; i++)
				send_live(value_char());
		end
	endtask

	task automatic send_field_line(input string name);
		int r;
		send_text(name);
		r = $urandom_range(0, 99);
		if (r < 85) begin
			send_live(CH_COLON);
			if (r < 50)
				send_live(CH_SPACE);
			else if (r < 58)
				send_text("  ");
			send_value();
		end
	endtask

	task automatic random_line();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_field_line("data");
		end else if (r < 60) begin
			send_field_line("event");
		end else if (r < 68) begin
			send_live(CH_COLON);
			send_value();
		end else if (r < 75) begin
			case ($urandom_range(0, 5))
				0: send_field_line("id");
				1: send_field_line("retry");
				2: send_field_line("dat");
				3: send_field_line("events");
				4: send_field_line("Data");
				default: send_field_line("x");
			endcase
		end else if (r < 89) begin
			// blank line: closes the pending event
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_live(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			send_live(CH_LF);
		end else if (r < 95) begin
			send_live(CH_CR);
			send_live(CH_LF);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_blank_and_comment();
		// blank line with nothing pending gives no result; comment is skipped
		send_text("\n:note\n");
	endtask

	task automatic test_data_lines();
		// space stripped, byte extremes, CRLF ending, then a bare data field
		// that only adds the separator, then the event end
		send_text("data: ");
		send_live(8'h00);
		send_live(8'hFF);
		send_text("\r\ndata\n\n");
	endtask

	task automatic test_event_name();
		// lone CR inside the name: the byte after it yields two results;
		// bare "event" clears the name so the blank line closes nothing
		send_text("event:up\rx\nevent\n\nx:1\n");
	endtask

	task automatic test_random_traffic(input int n_bytes, input int s_pct,
			input int r_pct);
		int start;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes)
			random_line();
	endtask

	task automatic test_backpressure();
		// output held off while the input keeps offering, so the queue
		// fills and in_ready drops
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (5) send_text("data:ab\rcd\n");
		send_text("event:e\n\n");
	endtask

	task automatic test_stream_done();
		// finish any open line and event first, so the pending data below
		// is exactly the [DONE] value
		send_byte(CH_LF);
		send_byte(CH_LF);
		// [DONE] in mixed case with surrounding whitespace ends the stream;
		// everything after it is ignored
		send_text("data: [dOnE] \r\n");
		send_byte(CH_LF);
		send_text("data:z\n\n");
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_blank_and_comment();
		test_data_lines();
		test_event_name();
		test_random_traffic(200, 19, 45);
		test_random_traffic(200, 45, 19);
		test_backpressure();
		test_random_traffic(200, 0, 0);
		test_stream_done();

		in_valid <= 1'b0;
		while (out_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sse_event_stream_parser.f =====
+incdir+sv
sv/sep_pkg.sv
sv/sep_parser.sv
sv/sep_res_fifo.sv
sv/sse_event_stream_parser.sv
dv/tb_sse_event_stream_parser.sv
